// ----- src/assert_macros.svh -----
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/tlgc_pkg.sv -----
package tlgc_pkg;

  localparam int unsigned PAGE_COLUMNS_DEF = 128;
  localparam int unsigned MAX_CHARS_DEF    = 21;

  localparam int unsigned CELL_COLS  = 6;
  localparam int unsigned GLYPH_COLS = 5;

  localparam logic [6:0] FIRST_LETTER = 7'h41;
  localparam logic [6:0] LAST_LETTER  = 7'h55;
  localparam logic [6:0] LOWER_START  = 7'h61;
  localparam logic [6:0] CASE_OFFSET  = 7'd32;

  typedef enum logic [1:0] {
    MODE_APPEND = 2'd0,
    MODE_CLEAR  = 2'd1,
    MODE_FETCH  = 2'd2
  } mode_t;

  typedef struct packed {
    logic       written;
    logic       in_text;
    logic [2:0] pos;
  } fetch_t;

  // Five columns of one letter, column 0 in the low byte.
  function automatic logic [39:0] glyph_row(input logic [4:0] letter);
    logic [39:0] row;
    case (letter)
      5'd0:    row = {8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E};
      5'd1:    row = {8'h36, 8'h49, 8'h49, 8'h49, 8'h7F};
      5'd2:    row = {8'h22, 8'h41, 8'h41, 8'h41, 8'h3E};
      5'd3:    row = {8'h1C, 8'h22, 8'h41, 8'h41, 8'h7F};
      5'd4:    row = {8'h41, 8'h49, 8'h49, 8'h49, 8'h7F};
      5'd5:    row = {8'h01, 8'h09, 8'h09, 8'h09, 8'h7F};
      5'd7:    row = {8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F};
      5'd8:    row = {8'h00, 8'h41, 8'h7F, 8'h41, 8'h00};
      5'd10:   row = {8'h41, 8'h22, 8'h14, 8'h08, 8'h7F};
      5'd11:   row = {8'h40, 8'h40, 8'h40, 8'h40, 8'h7F};
      5'd12:   row = {8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F};
      5'd13:   row = {8'h7F, 8'h10, 8'h08, 8'h04, 8'h7F};
      5'd14:   row = {8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E};
      5'd17:   row = {8'h46, 8'h29, 8'h19, 8'h09, 8'h7F};
      5'd18:   row = {8'h31, 8'h49, 8'h49, 8'h49, 8'h46};
      5'd19:   row = {8'h01, 8'h01, 8'h7F, 8'h01, 8'h01};
      5'd20:   row = {8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F};
      default: row = 40'h0;
    endcase
    return row;
  endfunction

  function automatic logic [7:0] glyph_column(input logic [6:0] code, input logic [2:0] pos);
    logic [6:0]  c;
    logic [39:0] row;
    logic [7:0]  col_byte;
    c = code;
    if (c >= LOWER_START) begin
      c = c - CASE_OFFSET;
    end
    row = glyph_row(5'(c - FIRST_LETTER));
    if ((pos >= 3'(GLYPH_COLS)) || (c < FIRST_LETTER) || (c > LAST_LETTER)) begin
      col_byte = 8'h00;
    end else begin
      col_byte = row[{pos, 3'b000} +: 8];
    end
    return col_byte;
  endfunction

endpackage

// ----- src/tlgc_line_buf.sv -----
module tlgc_line_buf #(
  parameter int unsigned PAGE_COLUMNS = tlgc_pkg::PAGE_COLUMNS_DEF,
  parameter int unsigned MAX_CHARS    = tlgc_pkg::MAX_CHARS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic             clr_en,
  input  logic             rd_en,
  input  logic [6:0]       char_code,
  input  logic [6:0]       column,
  output tlgc_pkg::fetch_t fetch_r,
  output logic [6:0]       code_r
);
  import tlgc_pkg::*;

  localparam int unsigned CNT_W  = $clog2(MAX_CHARS + 1);
  localparam int unsigned ADDR_W = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;
  localparam int unsigned WID_W  = $clog2(MAX_CHARS * CELL_COLS + 1);
  localparam int unsigned PAGE_W = $clog2(PAGE_COLUMNS + 1);
  localparam int unsigned BIG_W  = (PAGE_W > WID_W) ? PAGE_W : WID_W;
  localparam int unsigned CMP_W  = (BIG_W > 8) ? BIG_W : 8;
  localparam logic [CMP_W-1:0] PAGE_C = CMP_W'(PAGE_COLUMNS);
  localparam logic [CMP_W-1:0] PAD0   = CMP_W'(PAGE_COLUMNS / 2);

  logic [6:0]       line_mem [MAX_CHARS];
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CMP_W-1:0] width_r, width_nxt;
  logic [CMP_W-1:0] pad_r, pad_nxt;

  logic [CMP_W-1:0] col_x, rel_x;
  logic [6:0]       rel;
  logic [14:0]      prod;
  logic [4:0]       idx;
  logic [6:0]       rem;
  logic [ADDR_W-1:0] rd_addr;
  logic             in_page, before_pad, in_text;
  fetch_t           fetch_nxt;

  always_comb begin
    count_nxt = count_r;
    width_nxt = width_r;
    if (clr_en) begin
      count_nxt = '0;
      width_nxt = '0;
    end else if (wr_en && (count_r < CNT_W'(MAX_CHARS))) begin
      count_nxt = count_r + CNT_W'(1);
      width_nxt = width_r + CMP_W'(CELL_COLS);
    end
    pad_nxt = (width_nxt < PAGE_C) ? ((PAGE_C - width_nxt) >> 1) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      width_r <= '0;
      pad_r   <= PAD0;
    end else begin
      count_r <= count_nxt;
      width_r <= width_nxt;
      pad_r   <= pad_nxt;
    end
  end

  // Column to cell index and offset; x171 >> 10 is an exact /6 for 7-bit values.
  always_comb begin
    col_x      = CMP_W'(column);
    in_page    = col_x < PAGE_C;
    before_pad = col_x < pad_r;
    rel_x      = col_x - pad_r;
    rel        = rel_x[6:0];
    in_text    = in_page && !before_pad && (rel_x < width_r);
    prod       = 15'(rel) * 15'd171;
    idx        = prod[14:10];
    rem        = rel - ({2'b00, idx} << 2) - ({2'b00, idx} << 1);
    rd_addr    = ADDR_W'(idx);
    fetch_nxt.written = in_page && (before_pad || in_text);
    fetch_nxt.in_text = in_text;
    fetch_nxt.pos     = rem[2:0];
  end

  always_ff @(posedge clk) begin
    if (wr_en && (count_r < CNT_W'(MAX_CHARS))) begin
      line_mem[count_r[ADDR_W-1:0]] <= char_code;
    end
    if (rd_en && in_text) begin
      code_r <= line_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      fetch_r <= fetch_nxt;
    end
  end

endmodule

// ----- src/tlgc_render.sv -----
module tlgc_render (
  input  logic             clk,
  input  logic             load,
  input  tlgc_pkg::fetch_t fetch,
  input  logic [6:0]       code,
  output logic [7:0]       column_byte,
  output logic             column_written
);
  import tlgc_pkg::*;

  logic [7:0] byte_r;
  logic       written_r;

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r    <= fetch.in_text ? glyph_column(code, fetch.pos) : 8'h00;
      written_r <= fetch.written;
    end
  end

  assign column_byte    = byte_r;
  assign column_written = written_r;

endmodule

// ----- src/text_line_glyph_columns.sv -----
// Centred text line renderer for a small graphic display page. Append, clear
// and fetch transactions are taken one per cycle unless stalled; append and
// clear take effect at acceptance and return nothing. A fetch's column byte
// goes through stages: the first reads the line buffer, the second looks up
// the 5x7 glyph ROM into the output register. Input stall rises only when both
// stages hold a fetch and the output is stalled. No clearing pass after reset.
`include "assert_macros.svh"

module text_line_glyph_columns #(
  parameter int unsigned PAGE_COLUMNS = tlgc_pkg::PAGE_COLUMNS_DEF,
  parameter int unsigned MAX_CHARS    = tlgc_pkg::MAX_CHARS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_mode,
  input  logic [6:0] in_char_code,
  input  logic [6:0] in_column,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_column_byte,
  output logic       out_column_written
);
  import tlgc_pkg::*;

  logic   en_out, en1, acc;
  logic   s1_v_r, s1_v_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   wr_en, clr_en, rd_en;
  fetch_t fetch_r;
  logic [6:0] code_r;

  assign en_out = !out_valid_r || !out_stall;
  assign en1    = !s1_v_r || en_out;
  assign acc    = in_valid && en1;
  assign wr_en  = acc && (in_mode == MODE_APPEND);
  assign clr_en = acc && (in_mode == MODE_CLEAR);
  assign rd_en  = acc && (in_mode == MODE_FETCH);

  always_comb begin
    s1_v_nxt      = en1 ? rd_en : s1_v_r;
    out_valid_nxt = en_out ? s1_v_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_v_r      <= s1_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  tlgc_line_buf #(
    .PAGE_COLUMNS(PAGE_COLUMNS),
    .MAX_CHARS   (MAX_CHARS)
  ) u_line_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (wr_en),
    .clr_en   (clr_en),
    .rd_en    (rd_en),
    .char_code(in_char_code),
    .column   (in_column),
    .fetch_r  (fetch_r),
    .code_r   (code_r)
  );

  tlgc_render u_render (
    .clk           (clk),
    .load          (en_out && s1_v_r),
    .fetch         (fetch_r),
    .code          (code_r),
    .column_byte   (out_column_byte),
    .column_written(out_column_written)
  );

  assign in_stall  = !en1;
  assign out_valid = out_valid_r;

  `ASSERT_NOW(a_unwritten_blank, out_valid_r && !out_column_written, out_column_byte == 8'h00, "unwritten column not blank")
  `ASSERT_NEXT(a_fetch_enters, in_valid && !in_stall && (in_mode == MODE_FETCH), s1_v_r, "fetch lost")
  `ASSERT_NOW(a_stall_full, in_stall, s1_v_r && out_valid_r && out_stall, "stall with room")

endmodule
